@@ sv/addp_pkg.sv @@
// Package: widths, fixed-point constants, register indexes and shared types.
package addp_pkg;

  // Field and datapath widths
  localparam int ACC_W     = 24;  // input sample width
  localparam int SUM_W     = 40;  // per-axis accumulator
  localparam int CNT_W     = 16;  // samples per period
  localparam int BIAS_W    = 40;  // Q10 with 16 extra fraction bits
  localparam int OUT_W     = 16;  // saturated result
  localparam int PKT_NUM_W = 6;
  localparam int ELEM_W    = 4;

  // Divider: quotient magnitude always fits in ACC_W bits
  localparam int DIV_STEPS = ACC_W;
  localparam int STEP_W    = 5;
  localparam int REM_W     = SUM_W - ACC_W;

  // Bias and output arithmetic
  localparam int AVG_W     = ACC_W + 1;
  localparam int FRAC_W    = 16;
  localparam int A16_W     = AVG_W + FRAC_W;
  localparam int ERR_W     = A16_W + 1;
  localparam int PROD_W    = ERR_W + 9;
  localparam int SCL_W     = ERR_W + 10;
  localparam int OUT_FRAC  = 26;

  localparam logic signed [9:0]        ALPHA_Q16  = 10'sd328;
  localparam logic signed [10:0]       SCALE_NUM  = 11'sd1023;
  localparam logic signed [17:0]       ROUND_HALF = 18'sd32768;
  localparam logic signed [27:0]       TRUNC_ADD  = 28'sd67108863;
  localparam logic signed [BIAS_W-1:0] GRAVITY_Q10 = 40'sd10045;
  localparam logic signed [BIAS_W-1:0] BIAS_Z_RESET = -(GRAVITY_Q10 <<< FRAC_W);
  localparam logic signed [OUT_W-1:0]  OUT_MAX = 16'sh7fff;
  localparam logic signed [OUT_W-1:0]  OUT_MIN = 16'sh8000;
  localparam logic [CNT_W-1:0]         COUNT_MAX = '1;

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ENABLE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WINDOW = 4'd1;

  // One stored packet entry
  typedef struct packed {
    logic signed [OUT_W-1:0] z;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] x;
  } entry_t;

endpackage

@@ sv/addp_if.sv @@
// Channel interfaces: sample input, result output and configuration writes.
interface addp_sample_if
  import addp_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [ACC_W-1:0] accel_x;
  logic signed [ACC_W-1:0] accel_y;
  logic signed [ACC_W-1:0] accel_z;
  logic                    close_period;

  modport source (output valid, accel_x, accel_y, accel_z, close_period, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, close_period, output ready);
endinterface

interface addp_result_if
  import addp_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [PKT_NUM_W-1:0]    packet_number;
  logic [ELEM_W-1:0]       element;
  logic signed [OUT_W-1:0] out_x;
  logic signed [OUT_W-1:0] out_y;
  logic signed [OUT_W-1:0] out_z;
  logic                    last;

  modport source (output valid, packet_number, element, out_x, out_y, out_z, last,
                  input ready);
  modport sink   (input valid, packet_number, element, out_x, out_y, out_z, last,
                  output ready);
endinterface

interface addp_cfg_if
  import addp_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/accel_decimate_debias_packetizer_top.sv @@
// Top level: decimating three-axis averager with DC bias removal and packetizer.
//
//  channel  dir  handshake     payload
//  -------  ---  ------------  ------------------------------------------------
//  sample   in   valid/ready   accel_x/y/z (s24), close_period
//  result   out  valid/ready   packet_number, element, out_x/y/z (s16), last
//  cfg      in   valid/ready   index, data (ready always high)
//
// A sample that does not close a period is summed in the idle state. A closing
// sample then runs, per axis, one load and 24 steps of the shared restoring divider
// plus the error, multiply, bias update, second error, scale and saturate states,
// then a store of the entry. Once the store is full, the packet is sent beat by beat,
// each beat read, shown and held until result.ready; sample.ready stays low from the
// closing beat until the last result beat. Synchronous reset; no clearing pass.
module accel_decimate_debias_packetizer_top
  import addp_pkg::*;
#(
  parameter int PACKET_LEN = 16,
  parameter int MAX_WINDOW = 1024
) (
  input  logic     clk,
  input  logic     rst,
  addp_sample_if.sink   sample,
  addp_result_if.source result,
  addp_cfg_if.sink      cfg
);

  localparam int AW = $clog2(PACKET_LEN);

  // Packet number wrap for each window code
  localparam int WIN0  = (16 > MAX_WINDOW) ? MAX_WINDOW : 16;
  localparam int WIN1  = (64 > MAX_WINDOW) ? MAX_WINDOW : 64;
  localparam int WIN2  = (256 > MAX_WINDOW) ? MAX_WINDOW : 256;
  localparam int WIN3  = (1024 > MAX_WINDOW) ? MAX_WINDOW : 1024;
  localparam int WRAP0 = (WIN0 / PACKET_LEN == 0) ? 1 : WIN0 / PACKET_LEN;
  localparam int WRAP1 = (WIN1 / PACKET_LEN == 0) ? 1 : WIN1 / PACKET_LEN;
  localparam int WRAP2 = (WIN2 / PACKET_LEN == 0) ? 1 : WIN2 / PACKET_LEN;
  localparam int WRAP3 = (WIN3 / PACKET_LEN == 0) ? 1 : WIN3 / PACKET_LEN;
  localparam int PCW   = (WRAP3 > 1) ? $clog2(WRAP3) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_DLOAD, S_DIV, S_ERR, S_MUL, S_BUPD, S_DIFF, S_SCALE, S_SAT,
    S_STORE, S_RD, S_SHOW, S_WAIT
  } state_t;

  state_t state;

  // Configuration
  logic       enable;
  logic [1:0] window_code;

  // Accumulation and bias state
  logic signed [SUM_W-1:0]  sums [3];
  logic        [CNT_W-1:0]  count;
  logic signed [BIAS_W-1:0] bias [3];
  logic        [AW-1:0]     fill;
  logic        [PCW-1:0]    pkt;
  logic        [1:0]        axis;

  // Divider and arithmetic registers
  logic        [REM_W-1:0]     rem;
  logic        [ACC_W-1:0]     dq;
  logic                        dneg;
  logic        [STEP_W-1:0]    step;
  logic signed [ERR_W-1:0]     err;
  logic signed [PROD_W-1:0]    prod;
  logic signed [SCL_W-1:0]     scl;
  logic signed [OUT_W-1:0]     res [3];

  // Packet store and dump
  entry_t          mem [PACKET_LEN];
  entry_t          rd_data;
  logic [AW-1:0]   k;

  // Result register
  logic                 out_valid;
  logic [PKT_NUM_W-1:0] out_pkt;
  logic [ELEM_W-1:0]    out_elem;
  entry_t               out_val;
  logic                 out_last;

  // Combinational datapath
  logic signed [SUM_W-1:0]  sum_cur;
  logic        [SUM_W-1:0]  mag;
  logic        [REM_W:0]    trial;
  logic                     fits;
  logic signed [AVG_W-1:0]  avg;
  logic signed [A16_W-1:0]  avg16;
  logic signed [ERR_W-1:0]  diff_cur;
  logic signed [PROD_W-1:0] bstep;
  logic signed [SCL_W-1:0]  scl_adj;
  logic signed [SCL_W-1:0]  tq;
  logic signed [OUT_W-1:0]  sat_val;
  logic        [PCW:0]      wrap_sel;
  logic        [PCW:0]      pkt_inc;
  logic                     wr_en;

  assign sample.ready = (state == S_IDLE);
  assign cfg.ready    = 1'b1;

  assign result.valid         = out_valid;
  assign result.packet_number = out_pkt;
  assign result.element       = out_elem;
  assign result.out_x         = out_val.x;
  assign result.out_y         = out_val.y;
  assign result.out_z         = out_val.z;
  assign result.last          = out_last;

  // Divider step: magnitude of the current sum, one quotient bit per cycle
  always_comb begin
    sum_cur = sums[axis];
    mag     = sum_cur[SUM_W-1] ? SUM_W'(-sum_cur) : SUM_W'(sum_cur);
    trial   = {rem, dq[ACC_W-1]};
    fits    = (trial >= {1'b0, count});
  end

  // Average, error against bias, rounded bias step
  always_comb begin
    avg      = dneg ? -$signed({1'b0, dq}) : $signed({1'b0, dq});
    avg16    = {avg, {FRAC_W{1'b0}}};
    diff_cur = ERR_W'(avg16) - ERR_W'(bias[axis]);
    bstep    = (prod + PROD_W'(ROUND_HALF)) >>> FRAC_W;
  end

  // Truncate toward zero, then saturate to int16
  always_comb begin
    scl_adj = scl + (scl[SCL_W-1] ? SCL_W'(TRUNC_ADD) : SCL_W'(0));
    tq      = scl_adj >>> OUT_FRAC;
    if (tq > SCL_W'(OUT_MAX)) begin
      sat_val = OUT_MAX;
    end else if (tq < SCL_W'(OUT_MIN)) begin
      sat_val = OUT_MIN;
    end else begin
      sat_val = OUT_W'(tq);
    end
  end

  // Packet number wrap for the active window
  always_comb begin
    case (window_code)
      2'd0:    wrap_sel = (PCW+1)'(WRAP0);
      2'd1:    wrap_sel = (PCW+1)'(WRAP1);
      2'd2:    wrap_sel = (PCW+1)'(WRAP2);
      default: wrap_sel = (PCW+1)'(WRAP3);
    endcase
    pkt_inc = (PCW+1)'(pkt) + (PCW+1)'(1);
  end

  assign wr_en = (state == S_STORE);

  // Packet store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[fill] <= '{z: res[2], y: res[1], x: res[0]};
    end
    rd_data <= mem[k];
  end

  // Sequencer, state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      enable      <= 1'b0;
      window_code <= 2'd0;
      sums        <= '{default: '0};
      count       <= '0;
      bias        <= '{'0, '0, BIAS_Z_RESET};
      fill        <= '0;
      pkt         <= '0;
      axis        <= '0;
      step        <= '0;
      k           <= '0;
      out_valid   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (sample.valid && enable) begin
            if (count != COUNT_MAX) begin
              sums[0] <= sums[0] + SUM_W'(sample.accel_x);
              sums[1] <= sums[1] + SUM_W'(sample.accel_y);
              sums[2] <= sums[2] + SUM_W'(sample.accel_z);
              count   <= count + CNT_W'(1);
            end
            if (sample.close_period) begin
              axis  <= '0;
              state <= S_DLOAD;
            end
          end
        end
        // load |sum|; high part is already below the count
        S_DLOAD: begin
          rem   <= mag[SUM_W-1:ACC_W];
          dq    <= mag[ACC_W-1:0];
          dneg  <= sum_cur[SUM_W-1];
          step  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem  <= fits ? REM_W'(trial - {1'b0, count}) : trial[REM_W-1:0];
          dq   <= {dq[ACC_W-2:0], fits};
          step <= step + STEP_W'(1);
          if (step == STEP_W'(DIV_STEPS - 1)) begin
            state <= S_ERR;
          end
        end
        S_ERR: begin
          err   <= diff_cur;
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= PROD_W'(err) * PROD_W'(ALPHA_Q16);
          state <= S_BUPD;
        end
        S_BUPD: begin
          bias[axis] <= bias[axis] + BIAS_W'(bstep);
          state      <= S_DIFF;
        end
        // error again, now against the updated bias
        S_DIFF: begin
          err   <= diff_cur;
          state <= S_SCALE;
        end
        S_SCALE: begin
          scl   <= SCL_W'(err) * SCL_W'(SCALE_NUM);
          state <= S_SAT;
        end
        S_SAT: begin
          res[axis]  <= sat_val;
          sums[axis] <= '0;
          if (axis == 2'd2) begin
            state <= S_STORE;
          end else begin
            axis  <= axis + 2'd1;
            state <= S_DLOAD;
          end
        end
        S_STORE: begin
          count <= '0;
          if (fill == AW'(PACKET_LEN - 1)) begin
            fill  <= '0;
            k     <= '0;
            state <= S_RD;
          end else begin
            fill  <= fill + AW'(1);
            state <= S_IDLE;
          end
        end
        // read data for entry k lands at the end of this cycle
        S_RD: begin
          state <= S_SHOW;
        end
        S_SHOW: begin
          out_valid <= 1'b1;
          out_pkt   <= PKT_NUM_W'(pkt);
          out_elem  <= ELEM_W'(k);
          out_val   <= rd_data;
          out_last  <= (k == AW'(PACKET_LEN - 1));
          state     <= S_WAIT;
        end
        S_WAIT: begin
          if (result.ready) begin
            out_valid <= 1'b0;
            if (k == AW'(PACKET_LEN - 1)) begin
              pkt   <= (pkt_inc >= wrap_sel) ? '0 : pkt_inc[PCW-1:0];
              state <= S_IDLE;
            end else begin
              k     <= k + AW'(1);
              state <= S_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // Register writes; a new window restarts averaging and packets
      if (cfg.valid) begin
        case (cfg.index)
          CFG_IDX_ENABLE: begin
            enable <= cfg.data[0];
          end
          CFG_IDX_WINDOW: begin
            if (cfg.data[1:0] != window_code) begin
              window_code <= cfg.data[1:0];
              sums        <= '{default: '0};
              count       <= '0;
              bias        <= '{'0, '0, BIAS_Z_RESET};
              fill        <= '0;
              pkt         <= '0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

@@ sv/addp_checker.sv @@
// Port-level checker for the top level, with its bind statement.
module addp_checker
  import addp_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              sample_ready,
  input logic              result_valid,
  input logic              result_ready,
  input logic              result_last,
  input logic [ELEM_W-1:0] result_element,
  input logic [OUT_W-1:0]  result_out_x
);

  // No new samples while a packet is being sent
  a_busy_while_sending: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !sample_ready)
    else $error("sample.ready high while a result is pending");

  // The last beat of a packet ends the dump
  a_last_ends_packet: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && result_last |=> !result_valid)
    else $error("result still valid after last beat");

  // Stalled result beat holds
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(result_element) && $stable(result_out_x))
    else $error("stalled result beat changed");

  // Reset leaves the block idle and ready
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !result_valid && sample_ready)
    else $error("block not idle after reset");

endmodule

bind accel_decimate_debias_packetizer_top addp_checker u_addp_checker (
  .clk            (clk),
  .rst            (rst),
  .sample_ready   (sample.ready),
  .result_valid   (result.valid),
  .result_ready   (result.ready),
  .result_last    (result.last),
  .result_element (result.element),
  .result_out_x   (result.out_x)
);

@@ test/accel_decimate_debias_packetizer_top_tb.sv @@
// Self-checking testbench for the decimating accelerometer averager and packetizer.
module accel_decimate_debias_packetizer_top_tb
  import addp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // Behavioral constants of the averager (own copy, independent of the RTL)
  localparam longint BIAS_ALPHA   = 328;          // 0.005 in Q16
  localparam longint BIAS_ROUND   = 32768;
  localparam longint GAIN_NUM     = 1023;
  localparam longint GAIN_DIV     = 67108864;     // 2^26
  localparam longint Z_BIAS_INIT  = -10045 * 65536;
  localparam longint SAT_HI       = 32767;
  localparam longint SAT_LO       = -32768;
  localparam int     PKT_LEN      = 16;
  localparam int     WINDOW_BASE  = 16;
  localparam int     WINDOW_CAP   = 1024;
  localparam int     COUNT_LIMIT  = 65535;

  // Stimulus constants
  localparam logic signed [ACC_W-1:0] ACC_MAX = 24'sh7fffff;
  localparam logic signed [ACC_W-1:0] ACC_MIN = 24'sh800000;
  localparam logic signed [ACC_W-1:0] GRAV    = 24'sd10045;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 4'd9;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP    = 4'hf;
  localparam int SETTLE      = 150;       // margin for a closing sample, which runs without output
  localparam int HOLD_CYCLES = 3000;      // longer than sixteen closing samples
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct {
    logic [PKT_NUM_W-1:0]    pkt;
    logic [ELEM_W-1:0]       elem;
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
    logic                    last;
  } beat_t;

  // Predicts packets from accepted samples and checks result beats in order
  class accel_packet_checker;
    longint      sums[3];
    int unsigned count;
    longint      bias[3];
    entry_t      store[PKT_LEN];
    int unsigned fill;
    int unsigned pkt_ctr;
    bit          enable;
    bit [1:0]    window;
    beat_t       beats[$];
    int          errors;
    int          samples;
    int          results;
    int          packets;

    function new();
      enable  = 1'b0;
      window  = 2'd0;
      errors  = 0;
      samples = 0;
      results = 0;
      packets = 0;
      clear_path();
    endfunction

    function void clear_path();
      sums    = '{0, 0, 0};
      count   = 0;
      bias    = '{0, 0, Z_BIAS_INIT};
      fill    = 0;
      pkt_ctr = 0;
    endfunction

    function int unsigned wrap_len();
      int unsigned span;
      int unsigned wrap;
      span = WINDOW_BASE << (2 * window);
      if (span > WINDOW_CAP) span = WINDOW_CAP;
      wrap = span / PKT_LEN;
      return (wrap == 0) ? 1 : wrap;
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_IDX_ENABLE) begin
        enable = val[0];
      end else if (idx == CFG_IDX_WINDOW && val[1:0] != window) begin
        // window change restarts the whole averaging path
        window = val[1:0];
        clear_path();
      end
    endfunction

    function void take_sample(logic signed [ACC_W-1:0] ax, ay, az, logic close);
      longint acc[3];
      longint avg, avg16, diff, scaled;
      logic signed [OUT_W-1:0] res[3];
      beat_t b;
      int a;
      int k;
      if (!enable) return;
      samples++;
      acc[0] = ax;
      acc[1] = ay;
      acc[2] = az;
      // saturated count: further samples are neither summed nor counted
      if (count < COUNT_LIMIT) begin
        for (a = 0; a < 3; a++) sums[a] += acc[a];
        count++;
      end
      if (!close) return;
      for (a = 0; a < 3; a++) begin
        avg     = sums[a] / longint'(count);
        avg16   = avg * 65536;
        bias[a] += (BIAS_ALPHA * (avg16 - bias[a]) + BIAS_ROUND) >>> 16;
        diff    = avg16 - bias[a];
        scaled  = (diff * GAIN_NUM) / GAIN_DIV;
        if (scaled > SAT_HI) scaled = SAT_HI;
        if (scaled < SAT_LO) scaled = SAT_LO;
        res[a]  = scaled[OUT_W-1:0];
        sums[a] = 0;
      end
      store[fill].x = res[0];
      store[fill].y = res[1];
      store[fill].z = res[2];
      count = 0;
      fill++;
      if (fill < PKT_LEN) return;
      // store full: the whole packet goes out
      for (k = 0; k < PKT_LEN; k++) begin
        b.pkt  = PKT_NUM_W'(pkt_ctr);
        b.elem = ELEM_W'(k);
        b.x    = store[k].x;
        b.y    = store[k].y;
        b.z    = store[k].z;
        b.last = (k == PKT_LEN - 1);
        beats.push_back(b);
      end
      fill    = 0;
      pkt_ctr = (pkt_ctr + 1) % wrap_len();
    endfunction

    function int pending();
      return beats.size();
    endfunction

    task report(string what);
      errors++;
      if (errors <= 25) $display("MISMATCH: %s", what);
    endtask

    task check_beat(beat_t got);
      beat_t want;
      results++;
      if (got.last === 1'b1) packets++;
      if (beats.size() == 0) begin
        report($sformatf("unexpected beat pkt %0d elem %0d", got.pkt, got.elem));
        return;
      end
      want = beats.pop_front();
      if (got.pkt !== want.pkt)
        report($sformatf("packet_number got %0d want %0d", got.pkt, want.pkt));
      if (got.elem !== want.elem)
        report($sformatf("element got %0d want %0d", got.elem, want.elem));
      if (got.x !== want.x)
        report($sformatf("pkt %0d elem %0d out_x got %0d want %0d",
                         want.pkt, want.elem, got.x, want.x));
      if (got.y !== want.y)
        report($sformatf("pkt %0d elem %0d out_y got %0d want %0d",
                         want.pkt, want.elem, got.y, want.y));
      if (got.z !== want.z)
        report($sformatf("pkt %0d elem %0d out_z got %0d want %0d",
                         want.pkt, want.elem, got.z, want.z));
      if (got.last !== want.last)
        report($sformatf("pkt %0d elem %0d last got %0b want %0b",
                         want.pkt, want.elem, got.last, want.last));
    endtask

    task flag_leftover();
      if (beats.size() != 0)
        report($sformatf("%0d expected beats never arrived", beats.size()));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  int   cycle_count = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   hold_reqs = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  beat_t seen_beat;
  accel_packet_checker sb;

  addp_sample_if sample_ch ();
  addp_result_if result_ch ();
  addp_cfg_if    cfg_ch ();

  accel_decimate_debias_packetizer_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always #2 clk = ~clk;

  // Run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result ready: random stalls plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left--;
    end
    result_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
  end

  // Beat monitor: configuration, accepted samples and result beats
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.apply_reg(cfg_ch.index, cfg_ch.data);
      if (sample_ch.valid && sample_ch.ready)
        sb.take_sample(sample_ch.accel_x, sample_ch.accel_y, sample_ch.accel_z,
                       sample_ch.close_period);
      if (result_ch.valid && result_ch.ready) begin
        seen_beat.pkt  = result_ch.packet_number;
        seen_beat.elem = result_ch.element;
        seen_beat.x    = result_ch.out_x;
        seen_beat.y    = result_ch.out_y;
        seen_beat.z    = result_ch.out_z;
        seen_beat.last = result_ch.last;
        sb.check_beat(seen_beat);
      end
    end
  end

  // Mix of extremes, full-range and near-gravity magnitudes
  function automatic logic signed [ACC_W-1:0] pick_accel();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return ACC_MAX;
    if (r == 1) return ACC_MIN;
    if (r <= 4) return ACC_W'($urandom);
    return ACC_W'($signed($urandom_range(80000)) - 40000);
  endfunction

  task automatic send_sample(input logic signed [ACC_W-1:0] ax, ay, az, input logic close);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid        <= 1'b1;
    sample_ch.accel_x      <= ax;
    sample_ch.accel_y      <= ay;
    sample_ch.accel_z      <= az;
    sample_ch.close_period <= close;
    do @(posedge clk); while (!(sample_ch.valid && sample_ch.ready));
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stop sending, wait for every expected beat, then let the block go quiet
  task automatic wait_drain(input int settle);
    sample_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic run_random(input int items);
    int n;
    for (n = 0; n < items; n++)
      send_sample(pick_accel(), pick_accel(), pick_accel(), $urandom_range(2) != 0);
  endtask

  initial begin
    int k;
    sb = new();
    rst                    = 1'b1;
    sample_ch.valid        = 1'b0;
    sample_ch.accel_x      = '0;
    sample_ch.accel_y      = '0;
    sample_ch.accel_z      = '0;
    sample_ch.close_period = 1'b0;
    result_ch.ready        = 1'b0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.index           = '0;
    cfg_ch.data            = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // acquisition off after reset: these samples are dropped
    send_sample(ACC_MAX, ACC_MIN, ACC_MAX, 1'b0);
    send_sample(ACC_MIN, ACC_MAX, ACC_MIN, 1'b1);
    send_sample(pick_accel(), pick_accel(), pick_accel(), 1'b1);
    wait_drain(SETTLE);
    cfg_write(CFG_IDX_ENABLE, 8'h01);
    cfg_write(CFG_IDX_UNUSED, 8'h03);     // out-of-range indexes do nothing
    cfg_write(CFG_IDX_TOP, 8'hff);
    cfg_write(CFG_IDX_WINDOW, 8'h00);     // same window: no clear

    // field extremes, then enough closes for one packet plus two
    send_sample(ACC_MAX, ACC_MAX, ACC_MIN, 1'b0);
    send_sample(ACC_MAX, ACC_MIN, 24'sd0, 1'b1);
    send_sample(ACC_MIN, ACC_MAX, -24'sd1, 1'b1);
    send_sample(24'sd0, 24'sd0, -GRAV, 1'b1);
    send_sample(24'sd1, -24'sd1, 24'sd0, 1'b1);
    for (k = 0; k < 14; k++) send_sample(pick_accel(), pick_accel(), pick_accel(), 1'b1);
    wait_drain(SETTLE);

    // only bit 0 of the enable write counts
    cfg_write(CFG_IDX_ENABLE, 8'hfe);
    send_sample(ACC_MAX, ACC_MAX, ACC_MAX, 1'b1);
    send_sample(ACC_MIN, ACC_MIN, ACC_MIN, 1'b1);
    wait_drain(SETTLE);
    cfg_write(CFG_IDX_ENABLE, 8'h01);
    // masked to the largest window; clears a partly filled store
    cfg_write(CFG_IDX_WINDOW, 8'h07);

    // 64-sample window: packet number runs 0..3 and wraps back to 0
    cfg_write(CFG_IDX_WINDOW, 8'h01);
    for (k = 0; k < 5 * PKT_LEN; k++)
      send_sample(pick_accel(), pick_accel(), pick_accel(), 1'b1);
    wait_drain(SETTLE);

    // random: no idling, smallest window
    cfg_write(CFG_IDX_WINDOW, 8'h00);
    run_random(40);
    wait_drain(SETTLE);

    // random: sender idles, with one pause until all beats are out
    cfg_write(CFG_IDX_WINDOW, 8'h01);
    send_idle_pct = 66;
    run_random(25);
    wait_drain(0);
    run_random(25);
    wait_drain(SETTLE);

    // random: receiver stalls, with a long hold-off that backs up the input
    cfg_write(CFG_IDX_WINDOW, 8'h02);
    send_idle_pct  = 0;
    recv_stall_pct = 66;
    run_random(20);
    hold_reqs++;
    for (k = 0; k < 20; k++)
      send_sample(pick_accel(), pick_accel(), pick_accel(), 1'b1);
    run_random(15);
    wait_drain(SETTLE);

    // random: light idling on both sides, short stretch with acquisition off
    send_idle_pct  = 6;
    recv_stall_pct = 6;
    cfg_write(CFG_IDX_ENABLE, 8'h00);
    run_random(10);
    wait_drain(SETTLE);
    cfg_write(CFG_IDX_ENABLE, 8'h01);
    cfg_write(CFG_IDX_WINDOW, 8'h03);
    run_random(60);
    wait_drain(SETTLE);

    sb.flag_leftover();
    $display("Covered %0d enabled samples, %0d result beats in %0d packets,",
             sb.samples, sb.results, sb.packets);
    $display("all windows, enable on/off, window clears, number wrap, long output stall.");
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
